// File: rtl/core/rld_pkg.sv
`timescale 1ns / 1ps
package rld_pkg;

    localparam int MAX_COEFFS     = 3;

    localparam int PIX_W   = 16;
    localparam int FOCAL_W = 24;
    localparam int COEFF_W = 32;
    localparam int Q_W     = 32;
    localparam int OUT_W   = 20;
    localparam int K_W     = 40;
    localparam int PROD_W  = 64;

    localparam int DIV_FRAC   = 28;
    localparam int DIV_W      = PIX_W + DIV_FRAC;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_THIRD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEFFS_IN_USE = 3'd7;

    localparam logic signed [Q_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic [30:0]           P_MAX   = 31'h7FFF_FFFF;
    localparam logic signed [K_W-1:0] K_ONE   = 40'sh00_0100_0000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

    typedef struct packed {
        logic [FOCAL_W-1:0]        focal_x;
        logic [FOCAL_W-1:0]        focal_y;
        logic [PIX_W-1:0]          center_x;
        logic [PIX_W-1:0]          center_y;
        logic signed [COEFF_W-1:0] coeff_first;
        logic signed [COEFF_W-1:0] coeff_second;
        logic signed [COEFF_W-1:0] coeff_third;
        logic [1:0]                coeffs_in_use;
    } t_cfg;

    function automatic logic signed [COEFF_W-1:0] coeff_at(t_cfg cfg, int idx);
        logic signed [COEFF_W-1:0] c;
        case (idx)
            0:       c = cfg.coeff_first;
            1:       c = cfg.coeff_second;
            2:       c = cfg.coeff_third;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/radial_lens_distortion.sv
`timescale 1ns / 1ps
// throughput: one transaction per clock, set by the fully pipelined datapath
// (restoring divider at 4 quotient bits per stage, one stage per multiply)
// busy stays low since results are never held off downstream
// reset: synchronous active low, clears pipeline valid bits and resets config registers
module radial_lens_distortion
    import rld_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [PIX_W-1:0]        i_pixel_u,
    input  logic [PIX_W-1:0]        i_pixel_v,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_dist_u,
    output logic signed [OUT_W-1:0] o_dist_v,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg r_cfg;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x       <= FOCAL_W'(256);
            r_cfg.focal_y       <= FOCAL_W'(256);
            r_cfg.center_x      <= '0;
            r_cfg.center_y      <= '0;
            r_cfg.coeff_first   <= '0;
            r_cfg.coeff_second  <= '0;
            r_cfg.coeff_third   <= '0;
            r_cfg.coeffs_in_use <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FOCAL_X:       r_cfg.focal_x       <= i_cfg_data[FOCAL_W-1:0];
                REG_FOCAL_Y:       r_cfg.focal_y       <= i_cfg_data[FOCAL_W-1:0];
                REG_CENTER_X:      r_cfg.center_x      <= i_cfg_data[PIX_W-1:0];
                REG_CENTER_Y:      r_cfg.center_y      <= i_cfg_data[PIX_W-1:0];
                REG_COEFF_FIRST:   r_cfg.coeff_first   <= i_cfg_data;
                REG_COEFF_SECOND:  r_cfg.coeff_second  <= i_cfg_data;
                REG_COEFF_THIRD:   r_cfg.coeff_third   <= i_cfg_data;
                REG_COEFFS_IN_USE: r_cfg.coeffs_in_use <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic                  accept;
    logic                  vx, vy;
    logic signed [Q_W-1:0] xn, yn;

    assign accept = start && !busy;

    rld_divider u_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_pixel  (i_pixel_u),
        .i_center (r_cfg.center_x),
        .i_focal  (r_cfg.focal_x),
        .o_valid  (vx),
        .o_norm   (xn)
    );

    rld_divider u_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_pixel  (i_pixel_v),
        .i_center (r_cfg.center_y),
        .i_focal  (r_cfg.focal_y),
        .o_valid  (vy),
        .o_norm   (yn)
    );

    logic                  rad_vld;
    logic signed [Q_W-1:0] k, rxn, ryn;

    rld_radial u_radial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (vx && vy),
        .i_xn    (xn),
        .i_yn    (yn),
        .o_valid (rad_vld),
        .o_k     (k),
        .o_xn    (rxn),
        .o_yn    (ryn)
    );

    logic ou_vld, ov_vld;

    rld_remap u_remap_u (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rad_vld),
        .i_k      (k),
        .i_norm   (rxn),
        .i_focal  (r_cfg.focal_x),
        .i_center (r_cfg.center_x),
        .o_valid  (ou_vld),
        .o_dist   (o_dist_u)
    );

    rld_remap u_remap_v (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rad_vld),
        .i_k      (k),
        .i_norm   (ryn),
        .i_focal  (r_cfg.focal_y),
        .i_center (r_cfg.center_y),
        .o_valid  (ov_vld),
        .o_dist   (o_dist_v)
    );

    assign o_valid = ou_vld && ov_vld;

endmodule

// File: rtl/core/rld_divider.sv
`timescale 1ns / 1ps
module rld_divider
    import rld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic [PIX_W-1:0]      i_center,
    input  logic [FOCAL_W-1:0]    i_focal,
    output logic                  o_valid,
    output logic signed [Q_W-1:0] o_norm
);

    logic [FOCAL_W-1:0] divisor;
    logic [PIX_W:0]     diff;
    logic [PIX_W:0]     mag;

    logic               r_vld [0:DIV_STAGES];
    logic               r_neg [0:DIV_STAGES];
    logic [FOCAL_W-1:0] r_rem [0:DIV_STAGES];
    // dividend bits shift out at the top, quotient bits shift in at the bottom
    logic [DIV_W-1:0]   r_w   [0:DIV_STAGES];

    logic                  r_out_vld;
    logic signed [Q_W-1:0] r_norm;

    // a zero focal length divides as one
    assign divisor = (i_focal == '0) ? FOCAL_W'(1) : i_focal;
    assign diff    = {1'b0, i_pixel} - {1'b0, i_center};
    assign mag     = diff[PIX_W] ? ((PIX_W+1)'(0) - diff) : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_neg[0] <= diff[PIX_W];
        r_rem[0] <= '0;
        r_w[0]   <= {mag[PIX_W-1:0], {DIV_FRAC{1'b0}}};
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [FOCAL_W-1:0] rem;
        logic [DIV_W-1:0]   w;
        logic [FOCAL_W:0]   trial;

        always_comb begin
            rem   = r_rem[s];
            w     = r_w[s];
            trial = '0;
            for (int b = 0; b < DIV_STEP; b++) begin
                trial = {rem, w[DIV_W-1]};
                w     = {w[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor}) begin
                    rem  = FOCAL_W'(trial - {1'b0, divisor});
                    w[0] = 1'b1;
                end else begin
                    rem = trial[FOCAL_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_neg[s+1] <= r_neg[s];
            r_rem[s+1] <= rem;
            r_w[s+1]   <= w;
        end
    end

    logic [DIV_W-1:0] quo;
    logic             pos_ovf;
    logic             neg_ovf;

    assign quo     = r_w[DIV_STAGES];
    assign pos_ovf = |quo[DIV_W-1:Q_W-1];
    assign neg_ovf = (|quo[DIV_W-1:Q_W]) || (quo[Q_W-1] && (|quo[Q_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[DIV_STAGES];
        end
        if (r_neg[DIV_STAGES]) begin
            r_norm <= neg_ovf ? S32_MIN : (Q_W'(0) - quo[Q_W-1:0]);
        end else begin
            r_norm <= pos_ovf ? S32_MAX : quo[Q_W-1:0];
        end
    end

    assign o_valid = r_out_vld;
    assign o_norm  = r_norm;

endmodule

// File: rtl/core/rld_radial.sv
`timescale 1ns / 1ps
module rld_radial
    import rld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic signed [Q_W-1:0] i_xn,
    input  logic signed [Q_W-1:0] i_yn,
    output logic                  o_valid,
    output logic signed [Q_W-1:0] o_k,
    output logic signed [Q_W-1:0] o_xn,
    output logic signed [Q_W-1:0] o_yn
);

    // squares
    logic                     r_sq_vld;
    logic signed [PROD_W-1:0] r_sx, r_sy;
    logic signed [Q_W-1:0]    r_sq_xn, r_sq_yn;
    logic signed [PROD_W-1:0] xe, ye;

    assign xe = {{(PROD_W-Q_W){i_xn[Q_W-1]}}, i_xn};
    assign ye = {{(PROD_W-Q_W){i_yn[Q_W-1]}}, i_yn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= i_valid;
        end
        r_sx    <= xe * xe;
        r_sy    <= ye * ye;
        r_sq_xn <= i_xn;
        r_sq_yn <= i_yn;
    end

    logic [PROD_W-1:0] sq;
    assign sq = r_sx + r_sy;

    // per-term state, index j holds the values after j terms
    logic                  r_v  [0:MAX_COEFFS];
    logic [30:0]           r_p  [0:MAX_COEFFS];
    logic [30:0]           r_r2 [0:MAX_COEFFS];
    logic signed [K_W-1:0] r_k  [0:MAX_COEFFS];
    logic signed [Q_W-1:0] r_xs [0:MAX_COEFFS];
    logic signed [Q_W-1:0] r_ys [0:MAX_COEFFS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_sq_vld;
        end
        r_p[0]  <= (|sq[PROD_W-1:55]) ? P_MAX : sq[54:24];
        r_r2[0] <= (|sq[PROD_W-1:55]) ? P_MAX : sq[54:24];
        r_k[0]  <= K_ONE;
        r_xs[0] <= r_sq_xn;
        r_ys[0] <= r_sq_yn;
    end

    for (genvar i = 0; i < MAX_COEFFS; i++) begin : g_term
        logic signed [PROD_W-1:0] pa, ca;
        logic signed [COEFF_W-1:0] ci;
        logic [61:0]              pp;
        logic                     used;

        logic                     r_av;
        logic signed [PROD_W-1:0] r_pc;
        logic [61:0]              r_pp;
        logic [30:0]              r_ar2;
        logic signed [K_W-1:0]    r_ak;
        logic signed [Q_W-1:0]    r_axs, r_ays;

        assign ci   = coeff_at(i_cfg, i);
        assign pa   = {{(PROD_W-31){1'b0}}, r_p[i]};
        assign ca   = {{(PROD_W-COEFF_W){ci[COEFF_W-1]}}, ci};
        assign pp   = {31'd0, r_p[i]} * {31'd0, r_r2[i]};
        assign used = ({30'd0, i_cfg.coeffs_in_use} > 32'(i));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av <= 1'b0;
            end else begin
                r_av <= r_v[i];
            end
            r_pc  <= pa * ca;
            r_pp  <= pp;
            r_ar2 <= r_r2[i];
            r_ak  <= r_k[i];
            r_axs <= r_xs[i];
            r_ays <= r_ys[i];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_av;
            end
            if (used) begin
                r_k[i+1] <= r_ak + {{(K_W-36){r_pc[PROD_W-1]}}, r_pc[PROD_W-1:28]};
            end else begin
                r_k[i+1] <= r_ak;
            end
            r_p[i+1]  <= (|r_pp[61:55]) ? P_MAX : r_pp[54:24];
            r_r2[i+1] <= r_ar2;
            r_xs[i+1] <= r_axs;
            r_ys[i+1] <= r_ays;
        end
    end

    logic                  r_out_vld;
    logic signed [Q_W-1:0] r_kq, r_oxn, r_oyn;
    logic signed [K_W-1:0] kf;
    logic                  k_fits;

    assign kf     = r_k[MAX_COEFFS];
    assign k_fits = (&kf[K_W-1:Q_W-1]) || !(|kf[K_W-1:Q_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_v[MAX_COEFFS];
        end
        if (k_fits) begin
            r_kq <= kf[Q_W-1:0];
        end else begin
            r_kq <= kf[K_W-1] ? S32_MIN : S32_MAX;
        end
        r_oxn <= r_xs[MAX_COEFFS];
        r_oyn <= r_ys[MAX_COEFFS];
    end

    assign o_valid = r_out_vld;
    assign o_k     = r_kq;
    assign o_xn    = r_oxn;
    assign o_yn    = r_oyn;

endmodule

// File: rtl/core/rld_remap.sv
`timescale 1ns / 1ps
module rld_remap
    import rld_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [Q_W-1:0]   i_k,
    input  logic signed [Q_W-1:0]   i_norm,
    input  logic [FOCAL_W-1:0]      i_focal,
    input  logic [PIX_W-1:0]        i_center,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_dist
);

    logic [3:0] r_vld;

    logic signed [PROD_W-1:0] ke, ne;
    logic signed [PROD_W-1:0] r_scaled;
    logic signed [Q_W-1:0]    r_xd;
    logic signed [PROD_W-1:0] r_pix;
    logic signed [OUT_W-1:0]  r_dist;

    assign ke = {{(PROD_W-Q_W){i_k[Q_W-1]}}, i_k};
    assign ne = {{(PROD_W-Q_W){i_norm[Q_W-1]}}, i_norm};

    logic                     xd_fits;
    logic signed [PROD_W-1:0] xde, fe;
    logic signed [36:0]       sum;
    logic                     out_fits;

    assign xd_fits = (&r_scaled[PROD_W-1:55]) || !(|r_scaled[PROD_W-1:55]);
    assign xde     = {{(PROD_W-Q_W){r_xd[Q_W-1]}}, r_xd};
    assign fe      = {{(PROD_W-FOCAL_W){1'b0}}, i_focal};
    // back to pixels: floor shift of the product, then add the center
    assign sum      = {r_pix[PROD_W-1], r_pix[PROD_W-1:28]} + {21'd0, i_center};
    assign out_fits = (&sum[36:OUT_W-1]) || !(|sum[36:OUT_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
        r_scaled <= ke * ne;
        if (xd_fits) begin
            r_xd <= r_scaled[55:24];
        end else begin
            r_xd <= r_scaled[PROD_W-1] ? S32_MIN : S32_MAX;
        end
        r_pix <= xde * fe;
        if (out_fits) begin
            r_dist <= sum[OUT_W-1:0];
        end else begin
            r_dist <= sum[36] ? OUT_MIN : OUT_MAX;
        end
    end

    assign o_valid = r_vld[3];
    assign o_dist  = r_dist;

endmodule
